### rtl/clcd_ws_pkg.sv
// Shared types and constants for the 4-bit character LCD write sequencer.
// Holds the request/result transaction structs, request kinds, register indexes and
// the LCD command constants. No dependencies.
`default_nettype none

package clcd_ws_pkg;

  // Request kinds
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_CMD     = 3'd1;
  localparam logic [2:0] KIND_DATA    = 3'd2;
  localparam logic [2:0] KIND_CURSOR  = 3'd3;
  localparam logic [2:0] KIND_INIT    = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_CYCLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_WAIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_WAIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POWERUP_WAIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_INIT_WAIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_STEP_WAIT = 3'd6;

  // LCD command bytes and nibbles
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_HOME       = 8'h02;
  localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [3:0] NIB_WAKE       = 4'h3;
  localparam logic [3:0] NIB_4BIT       = 4'h2;
  localparam logic [1:0] ROW_SECOND     = 2'd1;

  // Initialization step markers
  localparam logic [3:0] STEP_NONE       = 4'd0;
  localparam logic [3:0] STEP_NIB_FIRST  = 4'd1;
  localparam logic [3:0] STEP_NIB_LAST   = 4'd4;
  localparam logic [3:0] STEP_BYTE_FIRST = 4'd5;
  localparam logic [3:0] STEP_BYTE_PRE_LAST = 4'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic [1:0] row;
    logic [5:0] col;
  } req_t;

  typedef struct packed {
    logic       rs_pin;
    logic [3:0] data_pins;
    logic       enable_pin;
    logic       busy_res;
    logic       accepted;
  } res_t;

  // Command bytes sent after the nibble wake-up sequence
  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = CMD_FUNC_SET;
      2'd1: b = CMD_DISPLAY_ON;
      2'd2: b = CMD_CLEAR;
      default: b = CMD_ENTRY_MODE;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### rtl/char_lcd_4bit_write_sequencer_core.sv
// Character LCD 4-bit write sequencer: pin sequencing state machine with a down-counter.
// The result of a transaction is registered and shown in the cycle after it is accepted.
// Throughput: one transaction per cycle; the output register frees on the same edge
// it is taken, so input ready only drops while a result waits unclaimed.
// Reset: asynchronous, active low; idle, pin state registers low, timing registers at defaults.
// Depends on clcd_ws_pkg.
`default_nettype none

module char_lcd_4bit_write_sequencer_core #(
  parameter int unsigned TIMER_BITS = 17
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire clcd_ws_pkg::req_t                   in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output clcd_ws_pkg::res_t                        out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [clcd_ws_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [clcd_ws_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // Largest count the timer can hold, kept one bit wider than 32 for the shift
  localparam logic [32:0] TMax = (33'd1 << TIMER_BITS) - 33'd1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_POWERUP,
    PH_EN_HIGH,
    PH_EN_CYCLE,
    PH_BYTE_WAIT,
    PH_INIT_WAIT
  } phase_e;

  // Load value for a wait: zero counts as one tick, long waits saturate
  function automatic logic [TIMER_BITS-1:0] timer_load(
    input logic [clcd_ws_pkg::CFG_DATA_W-1:0] v
  );
    logic [32:0] t;
    t = {{(33 - clcd_ws_pkg::CFG_DATA_W){1'b0}}, v};
    if (t == 33'd0) t = 33'd1;
    if (t > TMax) t = TMax;
    return t[TIMER_BITS-1:0];
  endfunction

  // Timing registers, zero-extended to the config data width for loading
  logic [7:0]  en_high_q;
  logic [9:0]  en_cycle_q;
  logic [11:0] write_wait_q;
  logic [15:0] clear_wait_q;
  logic [16:0] powerup_wait_q;
  logic [16:0] first_init_q;
  logic [16:0] init_step_wait_q;

  // Sequencer state
  phase_e                phase_q, phase_d;
  logic [3:0]            step_q, step_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic [TIMER_BITS-1:0] timer_dec;
  logic [7:0]            pend_q, pend_d;
  logic                  low_next_q, low_next_d;
  logic                  rs_q, rs_d;
  logic [3:0]            nib_q, nib_d;
  logic                  en_q, en_d;
  logic                  acc_d;
  logic [3:0]            step_inc;
  logic [7:0]            start_b;
  logic                  start_rs;
  logic                  start_go;
  logic                  pulse_go;
  logic [3:0]            pulse_nib;

  // Output register
  logic                  out_valid_q;
  clcd_ws_pkg::res_t     out_q;

  logic in_acc;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign timer_dec = (timer_q != '0) ? timer_q - TIMER_BITS'(1) : timer_q;
  assign step_inc  = step_q + 4'd1;

  // Next state for one tick: start a request when idle, else count down and
  // advance the phase when the count runs out.
  always_comb begin
    phase_d    = phase_q;
    step_d     = step_q;
    timer_d    = timer_q;
    pend_d     = pend_q;
    low_next_d = low_next_q;
    rs_d       = rs_q;
    nib_d      = nib_q;
    en_d       = en_q;
    acc_d      = 1'b0;
    start_go   = 1'b0;
    start_b    = pend_q;
    start_rs   = 1'b0;
    pulse_go   = 1'b0;
    pulse_nib  = nib_q;

    if (phase_q == PH_IDLE) begin
      if (in_data_i.kind >= clcd_ws_pkg::KIND_CMD &&
          in_data_i.kind <= clcd_ws_pkg::KIND_INIT) begin
        acc_d  = 1'b1;
        step_d = clcd_ws_pkg::STEP_NONE;
        unique case (in_data_i.kind)
          clcd_ws_pkg::KIND_CMD: begin
            start_go = 1'b1;
            start_b  = in_data_i.value;
          end
          clcd_ws_pkg::KIND_DATA: begin
            start_go = 1'b1;
            start_b  = in_data_i.value;
            start_rs = 1'b1;
          end
          clcd_ws_pkg::KIND_CURSOR: begin
            // Column stays below 0x40, so adding it to the row base is a concatenation
            start_go = 1'b1;
            start_b  = {1'b1, in_data_i.row == clcd_ws_pkg::ROW_SECOND, in_data_i.col};
          end
          default: begin
            step_d  = clcd_ws_pkg::STEP_NIB_FIRST;
            en_d    = 1'b0;
            phase_d = PH_POWERUP;
            timer_d = timer_load(powerup_wait_q);
          end
        endcase
      end
    end else begin
      timer_d = timer_dec;
      if (timer_dec == '0) begin
        unique case (phase_q)
          PH_POWERUP: begin
            rs_d      = 1'b0;
            pulse_go  = 1'b1;
            pulse_nib = clcd_ws_pkg::NIB_WAKE;
          end
          PH_EN_HIGH: begin
            en_d    = 1'b0;
            phase_d = PH_EN_CYCLE;
            timer_d = timer_load({7'd0, en_cycle_q});
          end
          PH_EN_CYCLE: begin
            if (step_q >= clcd_ws_pkg::STEP_NIB_FIRST &&
                step_q <= clcd_ws_pkg::STEP_NIB_LAST) begin
              phase_d = PH_INIT_WAIT;
              timer_d = (step_q == clcd_ws_pkg::STEP_NIB_FIRST) ?
                        timer_load(first_init_q) : timer_load(init_step_wait_q);
            end else if (!low_next_q) begin
              low_next_d = 1'b1;
              pulse_go   = 1'b1;
              pulse_nib  = pend_q[3:0];
            end else begin
              low_next_d = 1'b0;
              phase_d    = PH_BYTE_WAIT;
              // Clear and home need the long wait
              if (!rs_q && (pend_q == clcd_ws_pkg::CMD_CLEAR ||
                            pend_q == clcd_ws_pkg::CMD_HOME)) begin
                timer_d = timer_load({1'b0, clear_wait_q});
              end else begin
                timer_d = timer_load({5'd0, write_wait_q});
              end
            end
          end
          PH_INIT_WAIT: begin
            if (step_inc >= clcd_ws_pkg::STEP_NIB_FIRST &&
                step_inc <= clcd_ws_pkg::STEP_NIB_LAST) begin
              step_d    = step_inc;
              rs_d      = 1'b0;
              pulse_go  = 1'b1;
              pulse_nib = (step_inc == clcd_ws_pkg::STEP_NIB_LAST) ?
                          clcd_ws_pkg::NIB_4BIT : clcd_ws_pkg::NIB_WAKE;
            end else begin
              step_d   = clcd_ws_pkg::STEP_BYTE_FIRST;
              start_go = 1'b1;
              start_b  = clcd_ws_pkg::CMD_FUNC_SET;
            end
          end
          PH_BYTE_WAIT: begin
            if (step_q >= clcd_ws_pkg::STEP_BYTE_FIRST &&
                step_q <= clcd_ws_pkg::STEP_BYTE_PRE_LAST) begin
              step_d   = step_inc;
              start_go = 1'b1;
              start_b  = clcd_ws_pkg::init_byte(step_inc[1:0] - 2'd1);
            end else begin
              step_d  = clcd_ws_pkg::STEP_NONE;
              phase_d = PH_IDLE;
              timer_d = '0;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            timer_d = '0;
          end
        endcase
      end
    end

    // A new byte latches its value and register select, then pulses the high nibble
    if (start_go) begin
      pend_d     = start_b;
      rs_d       = start_rs;
      low_next_d = 1'b0;
      pulse_go   = 1'b1;
      pulse_nib  = start_b[7:4];
    end
    if (pulse_go) begin
      nib_d   = pulse_nib;
      en_d    = 1'b1;
      phase_d = PH_EN_HIGH;
      timer_d = timer_load({9'd0, en_high_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_high_q        <= 8'd2;
      en_cycle_q       <= 10'd50;
      write_wait_q     <= 12'd100;
      clear_wait_q     <= 16'd2000;
      powerup_wait_q   <= 17'd50000;
      first_init_q     <= 17'd5000;
      init_step_wait_q <= 17'd100000;
      phase_q          <= PH_IDLE;
      step_q           <= '0;
      timer_q          <= '0;
      pend_q           <= '0;
      low_next_q       <= 1'b0;
      rs_q             <= 1'b0;
      nib_q            <= '0;
      en_q             <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      // Register writes; indexes beyond the list are dropped
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          clcd_ws_pkg::REG_ENABLE_HIGH:     en_high_q        <= cfg_data_i[7:0];
          clcd_ws_pkg::REG_ENABLE_CYCLE:    en_cycle_q       <= cfg_data_i[9:0];
          clcd_ws_pkg::REG_WRITE_WAIT:      write_wait_q     <= cfg_data_i[11:0];
          clcd_ws_pkg::REG_CLEAR_WAIT:      clear_wait_q     <= cfg_data_i[15:0];
          clcd_ws_pkg::REG_POWERUP_WAIT:    powerup_wait_q   <= cfg_data_i;
          clcd_ws_pkg::REG_FIRST_INIT_WAIT: first_init_q     <= cfg_data_i;
          clcd_ws_pkg::REG_INIT_STEP_WAIT:  init_step_wait_q <= cfg_data_i;
          default: ;
        endcase
      end
      // Advance the sequencer once per accepted tick and capture its result
      if (in_acc) begin
        phase_q     <= phase_d;
        step_q      <= step_d;
        timer_q     <= timer_d;
        pend_q      <= pend_d;
        low_next_q  <= low_next_d;
        rs_q        <= rs_d;
        nib_q       <= nib_d;
        en_q        <= en_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q.rs_pin     <= rs_d;
      out_q.data_pins  <= nib_d;
      out_q.enable_pin <= en_d;
      out_q.busy_res   <= (phase_d != PH_IDLE);
      out_q.accepted   <= acc_d;
    end
  end

endmodule

`default_nettype wire

### rtl/clcd_ws_checker.sv
// Port-level assertions for the character LCD write sequencer, with its bind.
// Depends on clcd_ws_pkg and char_lcd_4bit_write_sequencer_core.
`default_nettype none

module clcd_ws_props (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_o,
  input wire clcd_ws_pkg::req_t                   in_data_i,
  input wire logic                                out_valid_o,
  input wire logic                                out_ready_i,
  input wire clcd_ws_pkg::res_t                   out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // A taken request always leaves the block busy
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.accepted |-> out_data_o.busy_res)
    else $error("accepted request without busy");

  // Enable only pulses inside a sequence
  a_en_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.enable_pin |-> out_data_o.busy_res)
    else $error("enable high while idle");

  // A plain tick is never reported as accepted
  a_tick_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.kind == clcd_ws_pkg::KIND_TICK
    |=> out_valid_o && !out_data_o.accepted)
    else $error("tick reported as accepted");

  // No result appears without an input transaction
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && in_ready_o) && (!out_valid_o || out_ready_i) |=> !out_valid_o)
    else $error("result without a transaction");

endmodule

bind char_lcd_4bit_write_sequencer_core clcd_ws_props u_clcd_ws_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
